FILE: rtl/psu_pkg.sv
package psu_pkg;

  localparam int unsigned MaxRowBytesDflt   = 4096;
  localparam int unsigned MaxPixelBytesDflt = 8;
  localparam int unsigned QueueDepth        = 4;
  localparam int unsigned RowBytesW         = 13;
  localparam int unsigned PixelBytesW       = 4;

  localparam logic [RowBytesW-1:0]   RowBytesRst   = RowBytesW'(1);
  localparam logic [PixelBytesW-1:0] PixelBytesRst = PixelBytesW'(1);

  // Register indexes on the configuration port.
  localparam logic REG_ROW_BYTES   = 1'b0;
  localparam logic REG_PIXEL_BYTES = 1'b1;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } psu_filt_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       image_start;
  } psu_in_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       bad_filter;
  } psu_out_t;

  typedef struct packed {
    logic [RowBytesW-1:0]   row_bytes;
    logic [PixelBytesW-1:0] bytes_per_pixel;
  } psu_cfg_t;

  // One data byte as classified by the front end.
  typedef struct packed {
    logic [7:0] data;
    psu_filt_e  filt;
    logic       row_end;
    logic       first_row;
    logic       row_edge;
  } psu_entry_t;

  // Left neighbour distance: zero acts as one, and the value saturates at the maximum.
  function automatic logic [PixelBytesW-1:0] clamp_bpp(
    input logic [PixelBytesW-1:0] bpp,
    input logic [PixelBytesW-1:0] max_bpp
  );
    logic [PixelBytesW-1:0] r;
    if (bpp == '0) begin
      r = PixelBytesW'(1);
    end else if (bpp > max_bpp) begin
      r = max_bpp;
    end else begin
      r = bpp;
    end
    return r;
  endfunction

endpackage

FILE: rtl/psu_ram.sv
module psu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/psu_queue.sv
module psu_queue #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = psu_pkg::QueueDepth,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             nempty_o
);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o   = (cnt_q == CntW'(Depth));
  assign nempty_o = (cnt_q != '0);
  assign rdata_o  = slot_q[rd_q];
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && nempty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/psu_front.sv
module psu_front #(
  parameter int unsigned MaxRowBytes   = psu_pkg::MaxRowBytesDflt,
  parameter int unsigned MaxPixelBytes = psu_pkg::MaxPixelBytesDflt,
  localparam int unsigned PosW = $clog2(MaxRowBytes)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psu_pkg::psu_cfg_t   cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  psu_pkg::psu_in_t    in_data_i,
  output logic                push_o,
  output psu_pkg::psu_entry_t entry_o,
  output logic [PosW-1:0]     pos_o,
  input  logic                full_i
);

  localparam int unsigned LenW = $clog2(MaxRowBytes + 1);
  localparam int unsigned CmpW = (LenW > psu_pkg::RowBytesW) ? LenW : psu_pkg::RowBytesW;

  logic [PosW-1:0]             pos_q, pos_d;
  logic                        await_q, await_d;
  logic                        first_q, first_d;
  psu_pkg::psu_filt_e          filt_q, filt_d, filt_new;
  logic [CmpW-1:0]             rb_ext, len;
  logic [psu_pkg::PixelBytesW-1:0] bpp;
  logic                        accept, take_filter, first_now, last;

  assign in_stall_o  = full_i;
  assign accept      = in_valid_i && !full_i;
  assign take_filter = await_q || in_data_i.image_start;
  assign first_now   = in_data_i.image_start ? 1'b1 : first_q;

  always_comb begin
    rb_ext = CmpW'(cfg_i.row_bytes);
    if (rb_ext == '0) begin
      len = CmpW'(1);
    end else if (rb_ext > CmpW'(MaxRowBytes)) begin
      len = CmpW'(MaxRowBytes);
    end else begin
      len = rb_ext;
    end
  end

  assign bpp  = psu_pkg::clamp_bpp(cfg_i.bytes_per_pixel,
                                   psu_pkg::PixelBytesW'(MaxPixelBytes));
  assign last = (CmpW'(pos_q) + CmpW'(1)) >= len;

  always_comb begin
    unique case (in_data_i.stream_byte)
      8'd0:    filt_new = psu_pkg::FILT_NONE;
      8'd1:    filt_new = psu_pkg::FILT_SUB;
      8'd2:    filt_new = psu_pkg::FILT_UP;
      8'd3:    filt_new = psu_pkg::FILT_AVG;
      8'd4:    filt_new = psu_pkg::FILT_PAETH;
      default: filt_new = psu_pkg::FILT_BAD;
    endcase
  end

  assign push_o            = accept && !take_filter;
  assign pos_o             = pos_q;
  assign entry_o.data      = in_data_i.stream_byte;
  assign entry_o.filt      = filt_q;
  assign entry_o.row_end   = last;
  assign entry_o.first_row = first_q;
  assign entry_o.row_edge  = pos_q < PosW'(bpp);

  always_comb begin
    pos_d   = pos_q;
    await_d = await_q;
    first_d = first_q;
    filt_d  = filt_q;
    if (accept) begin
      if (take_filter) begin
        // An image start in the middle of a row drops the rest of that row.
        filt_d  = filt_new;
        await_d = 1'b0;
        pos_d   = '0;
        first_d = first_now;
      end else if (last) begin
        await_d = 1'b1;
        first_d = 1'b0;
        pos_d   = '0;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      await_q <= 1'b1;
      first_q <= 1'b1;
      filt_q  <= psu_pkg::FILT_NONE;
    end else begin
      pos_q   <= pos_d;
      await_q <= await_d;
      first_q <= first_d;
      filt_q  <= filt_d;
    end
  end

endmodule

FILE: rtl/psu_back.sv
module psu_back #(
  parameter int unsigned MaxRowBytes   = psu_pkg::MaxRowBytesDflt,
  parameter int unsigned MaxPixelBytes = psu_pkg::MaxPixelBytesDflt,
  localparam int unsigned PosW = $clog2(MaxRowBytes)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psu_pkg::psu_cfg_t   cfg_i,
  input  logic                nempty_i,
  input  psu_pkg::psu_entry_t entry_i,
  input  logic [PosW-1:0]     pos_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output psu_pkg::psu_out_t   out_data_o
);

  localparam int unsigned WinIdxW = (MaxPixelBytes > 1) ? $clog2(MaxPixelBytes) : 1;

  psu_pkg::psu_entry_t s2_ent_q;
  logic [PosW-1:0]     s2_pos_q;
  logic                s2_v_q;
  logic                fwd_q;
  logic [7:0]          fwd_byte_q;
  logic [7:0]          left_q [MaxPixelBytes];
  logic [7:0]          ul_q   [MaxPixelBytes];
  logic                out_v_q;
  psu_pkg::psu_out_t   out_q;

  logic                adv, fire;
  logic [7:0]          ram_rdata, a, b, c, pred, pix;
  logic [8:0]          ab_sum;
  logic                bad;
  logic [psu_pkg::PixelBytesW-1:0] bpp;
  logic [WinIdxW-1:0]  widx;

  function automatic logic [7:0] paeth(input logic [7:0] pa_a, input logic [7:0] pa_b,
                                       input logic [7:0] pa_c);
    logic [9:0] s, t, da, db, dc;
    logic [7:0] r;
    s  = {2'b00, pa_a} + {2'b00, pa_b};
    t  = {1'b0, pa_c, 1'b0};
    da = (pa_b > pa_c) ? 10'(pa_b - pa_c) : 10'(pa_c - pa_b);
    db = (pa_a > pa_c) ? 10'(pa_a - pa_c) : 10'(pa_c - pa_a);
    dc = (s > t) ? (s - t) : (t - s);
    if (da <= db && da <= dc) begin
      r = pa_a;
    end else if (db <= dc) begin
      r = pa_b;
    end else begin
      r = pa_c;
    end
    return r;
  endfunction

  // The whole back end moves only when the output register can take a beat.
  assign adv   = !out_v_q || !out_stall_i;
  assign pop_o = adv && nempty_i;
  assign fire  = adv && s2_v_q;

  psu_ram #(
    .Width (8),
    .Depth (MaxRowBytes)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (fire),
    .waddr_i (s2_pos_q),
    .wdata_i (pix),
    .re_i    (pop_o),
    .raddr_i (pos_i),
    .rdata_o (ram_rdata)
  );

  assign bpp  = psu_pkg::clamp_bpp(cfg_i.bytes_per_pixel,
                                   psu_pkg::PixelBytesW'(MaxPixelBytes));
  assign widx = WinIdxW'(bpp - psu_pkg::PixelBytesW'(1));

  always_comb begin
    a      = s2_ent_q.row_edge ? 8'd0 : left_q[widx];
    b      = s2_ent_q.first_row ? 8'd0 : (fwd_q ? fwd_byte_q : ram_rdata);
    c      = (s2_ent_q.row_edge || s2_ent_q.first_row) ? 8'd0 : ul_q[widx];
    ab_sum = {1'b0, a} + {1'b0, b};
    bad    = 1'b0;
    case (s2_ent_q.filt)
      psu_pkg::FILT_NONE:  pred = 8'd0;
      psu_pkg::FILT_SUB:   pred = a;
      psu_pkg::FILT_UP:    pred = b;
      psu_pkg::FILT_AVG:   pred = ab_sum[8:1];
      psu_pkg::FILT_PAETH: pred = paeth(a, b, c);
      default: begin
        pred = 8'd0;
        bad  = 1'b1;
      end
    endcase
    pix = s2_ent_q.data + pred;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i < int'(MaxPixelBytes); i++) begin
        left_q[i] <= 8'd0;
        ul_q[i]   <= 8'd0;
      end
    end else if (adv) begin
      s2_v_q  <= nempty_i;
      out_v_q <= s2_v_q;
      if (s2_v_q) begin
        left_q[0] <= pix;
        ul_q[0]   <= b;
        for (int i = 1; i < int'(MaxPixelBytes); i++) begin
          left_q[i] <= left_q[i-1];
          ul_q[i]   <= ul_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s2_ent_q <= entry_i;
      s2_pos_q <= pos_i;
      // The line store is read in the same cycle that the previous byte writes it,
      // so a read of that very address takes the byte being written.
      fwd_q      <= s2_v_q && (s2_pos_q == pos_i);
      fwd_byte_q <= pix;
    end
    if (fire) begin
      out_q.pixel_byte <= pix;
      out_q.row_end    <= s2_ent_q.row_end;
      out_q.bad_filter <= bad;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/png_scanline_unfilter.sv
// PNG scanline reconstruction.
// The input channel takes the inflated image stream, one byte per beat. The
// first byte of each row selects the row's filter and gives no result; each
// following byte gives one output beat with the reconstructed byte, a row end
// mark on the last byte of the row, and a flag when the row's filter type was
// unknown. A beat with image_start set begins a new image and is its first
// filter byte. Row length and pixel size are set through the register port
// (row_bytes at 0x0, bytes_per_pixel at 0x4); the user must write them only
// while the block is idle, which the block itself does not enforce.
// Bytes are registered in the queue, back end stage and output register.
// One byte per cycle is taken while the output is not stalled, a rate set by
// the loop predicting from the byte just reconstructed, line store read ahead.
// Reset empties the pipeline, waits for a filter byte of a first row, and sets
// both registers to one; the line store needs no clearing. While the output
// is stalled the back end holds, the queue fills, and then input stall rises.
module png_scanline_unfilter #(
  parameter int unsigned MaxRowBytes   = psu_pkg::MaxRowBytesDflt,
  parameter int unsigned MaxPixelBytes = psu_pkg::MaxPixelBytesDflt
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  psu_pkg::psu_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output psu_pkg::psu_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned PosW   = $clog2(MaxRowBytes);
  localparam int unsigned EntryW = $bits(psu_pkg::psu_entry_t) + PosW;

  psu_pkg::psu_cfg_t   cfg_q;
  logic                cfg_we;
  logic                push, full, pop, nempty;
  psu_pkg::psu_entry_t f_entry, b_entry;
  logic [PosW-1:0]     f_pos, b_pos;
  logic [EntryW-1:0]   q_rdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_bytes       <= psu_pkg::RowBytesRst;
      cfg_q.bytes_per_pixel <= psu_pkg::PixelBytesRst;
    end else if (cfg_we) begin
      unique case (paddr[2])
        psu_pkg::REG_ROW_BYTES:
          cfg_q.row_bytes <= pwdata[psu_pkg::RowBytesW-1:0];
        psu_pkg::REG_PIXEL_BYTES:
          cfg_q.bytes_per_pixel <= pwdata[psu_pkg::PixelBytesW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      psu_pkg::REG_ROW_BYTES:   prdata = 32'(cfg_q.row_bytes);
      psu_pkg::REG_PIXEL_BYTES: prdata = 32'(cfg_q.bytes_per_pixel);
      default:                  prdata = '0;
    endcase
  end

  psu_front #(
    .MaxRowBytes   (MaxRowBytes),
    .MaxPixelBytes (MaxPixelBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .entry_o    (f_entry),
    .pos_o      (f_pos),
    .full_i     (full)
  );

  psu_queue #(
    .Width (EntryW),
    .Depth (psu_pkg::QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  ({f_entry, f_pos}),
    .full_o   (full),
    .pop_i    (pop),
    .rdata_o  (q_rdata),
    .nempty_o (nempty)
  );

  assign b_entry = q_rdata[EntryW-1:PosW];
  assign b_pos   = q_rdata[PosW-1:0];

  psu_back #(
    .MaxRowBytes   (MaxRowBytes),
    .MaxPixelBytes (MaxPixelBytes)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .nempty_i    (nempty),
    .entry_i     (b_entry),
    .pos_i       (b_pos),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
